// File: rtl/sclw_pkg.sv
// Shared types, constants and helpers of the supercover line cell walker.
`timescale 1ns / 1ps

package sclw_pkg;

    // Cell coordinate width and the widths that follow from it.
    localparam int COORD_BITS = 12;
    localparam int LEN_BITS   = COORD_BITS + 1;   // |dx|, |dy|, step count
    localparam int ERR_BITS   = COORD_BITS + 3;   // error term and error sums

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [LEN_BITS-1:0]          t_len;
    typedef logic [ERR_BITS-1:0]          t_err;

    typedef enum logic {
        CMD_START  = 1'b0,
        CMD_ANSWER = 1'b1
    } t_cmd;

    typedef enum logic {
        RES_PROBE = 1'b0,
        RES_DONE  = 1'b1
    } t_kind;

    typedef struct packed {
        t_cmd   command;
        t_coord start_x;
        t_coord start_y;
        t_coord dest_x;
        t_coord dest_y;
        logic   cell_in_bounds;
        logic   cell_occupied;
    } t_in_item;

    typedef struct packed {
        t_kind  result_kind;
        t_coord cell_x;
        t_coord cell_y;
        logic   collided;
        logic   hit_wall;
        t_coord block_x;
        t_coord block_y;
    } t_out_item;

    // Line setup derived from a start command.
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic y_major;
        t_len major_len;
        t_len minor_len;
        logic same_cell;
    } t_setup;

    // Walk state presented to the line step unit.
    typedef struct packed {
        t_coord walk_x;
        t_coord walk_y;
        logic   x_neg;
        logic   y_neg;
        logic   y_major;
        t_len   major_len;
        t_len   minor_len;
        t_err   err;
        t_err   err_prev;
    } t_adv_in;

    // Walk state after one line step, plus the next cell to probe.
    typedef struct packed {
        t_coord walk_x;
        t_coord walk_y;
        t_err   err;
        t_coord probe_x;
        t_coord probe_y;
        logic   side_pending;
    } t_adv_out;

    // Moves a coordinate one cell in the given direction.
    function automatic t_coord step_coord(input t_coord c, input logic neg);
        return neg ? t_coord'(c - t_coord'(1)) : t_coord'(c + t_coord'(1));
    endfunction

endpackage

// File: rtl/supercover_line_cell_walker.sv
// Top level of the supercover line cell walker: handshakes, walk state, results.
`timescale 1ns / 1ps

// Channel | Direction | Handshake                 | Payload
// input   | in        | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
// output  | out       | o_out_valid / i_out_ready | o_out_data (t_out_item)
//
// Every item passes an input register, the walk logic and a result register:
// the result register is loaded from the walk logic when the walk stage fires,
// and one item can be taken in every cycle while the output is not stalled. The
// rate is set by the single walk update (setup decode feeding the line step unit)
// between the two registers.
// Reset is synchronous and active low; it clears the valid flags, busy and the
// pending side cell. When a result waits on a stalled output, the input
// register still takes one more item; further input waits for the transfer.

module supercover_line_cell_walker import sclw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Input register.
    logic      r_in_valid;
    logic      n_in_valid;
    t_in_item  r_in;
    t_in_item  n_in;

    // Result register.
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    // Walk state.
    logic   r_busy,         n_busy;
    logic   r_side_pending, n_side_pending;
    t_coord r_pos_x,        n_pos_x;
    t_coord r_pos_y,        n_pos_y;
    t_coord r_walk_x,       n_walk_x;
    t_coord r_walk_y,       n_walk_y;
    t_coord r_probe_x,      n_probe_x;
    t_coord r_probe_y,      n_probe_y;
    logic   r_x_neg,        n_x_neg;
    logic   r_y_neg,        n_y_neg;
    logic   r_y_major,      n_y_major;
    t_len   r_major_len,    n_major_len;
    t_len   r_minor_len,    n_minor_len;
    t_err   r_err,          n_err;
    t_err   r_err_prev,     n_err_prev;
    t_len   r_step_count,   n_step_count;

    logic     in_xfer;
    logic     fire;
    logic     is_start;
    t_len     step_next;
    t_setup   setup;
    t_adv_in  adv_in;
    t_adv_out adv_out;

    // The walk stage moves whenever the result register is free or emptying.
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign is_start   = (r_in.command == CMD_START);
    assign step_next  = r_step_count + t_len'(1);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    sclw_setup u_setup (
        .i_item  (r_in),
        .o_setup (setup)
    );

    // A start runs its first line step from the start cell in the same pass.
    always_comb begin
        if (is_start) begin
            adv_in.walk_x    = r_in.start_x;
            adv_in.walk_y    = r_in.start_y;
            adv_in.x_neg     = setup.x_neg;
            adv_in.y_neg     = setup.y_neg;
            adv_in.y_major   = setup.y_major;
            adv_in.major_len = setup.major_len;
            adv_in.minor_len = setup.minor_len;
            adv_in.err       = ERR_BITS'(setup.major_len);
            adv_in.err_prev  = ERR_BITS'(setup.major_len);
        end else begin
            adv_in.walk_x    = r_walk_x;
            adv_in.walk_y    = r_walk_y;
            adv_in.x_neg     = r_x_neg;
            adv_in.y_neg     = r_y_neg;
            adv_in.y_major   = r_y_major;
            adv_in.major_len = r_major_len;
            adv_in.minor_len = r_minor_len;
            adv_in.err       = r_err;
            adv_in.err_prev  = r_err_prev;
        end
    end

    sclw_advance u_advance (
        .i_adv (adv_in),
        .o_adv (adv_out)
    );

    always_comb begin
        n_in_valid     = in_xfer ? 1'b1 : (fire ? 1'b0 : r_in_valid);
        n_in           = in_xfer ? i_in_data : r_in;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out          = r_out;

        n_busy         = r_busy;
        n_side_pending = r_side_pending;
        n_pos_x        = r_pos_x;
        n_pos_y        = r_pos_y;
        n_walk_x       = r_walk_x;
        n_walk_y       = r_walk_y;
        n_probe_x      = r_probe_x;
        n_probe_y      = r_probe_y;
        n_x_neg        = r_x_neg;
        n_y_neg        = r_y_neg;
        n_y_major      = r_y_major;
        n_major_len    = r_major_len;
        n_minor_len    = r_minor_len;
        n_err          = r_err;
        n_err_prev     = r_err_prev;
        n_step_count   = r_step_count;

        if (fire) begin
            unique case (r_in.command)
                CMD_START: begin
                    // A start always replaces any move in progress.
                    n_pos_x     = r_in.start_x;
                    n_pos_y     = r_in.start_y;
                    n_x_neg     = setup.x_neg;
                    n_y_neg     = setup.y_neg;
                    n_out_valid = 1'b1;
                    if (setup.same_cell) begin
                        // Already at the destination: finished, nothing probed.
                        n_walk_x          = r_in.start_x;
                        n_walk_y          = r_in.start_y;
                        n_probe_x         = r_in.start_x;
                        n_probe_y         = r_in.start_y;
                        n_busy            = 1'b0;
                        n_side_pending    = 1'b0;
                        n_out.result_kind = RES_DONE;
                        n_out.cell_x      = r_in.start_x;
                        n_out.cell_y      = r_in.start_y;
                    end else begin
                        n_y_major         = setup.y_major;
                        n_major_len       = setup.major_len;
                        n_minor_len       = setup.minor_len;
                        n_step_count      = '0;
                        n_busy            = 1'b1;
                        n_walk_x          = adv_out.walk_x;
                        n_walk_y          = adv_out.walk_y;
                        n_err             = adv_out.err;
                        n_err_prev        = adv_out.err;
                        n_probe_x         = adv_out.probe_x;
                        n_probe_y         = adv_out.probe_y;
                        n_side_pending    = adv_out.side_pending;
                        n_out.result_kind = RES_PROBE;
                        n_out.cell_x      = adv_out.probe_x;
                        n_out.cell_y      = adv_out.probe_y;
                    end
                    n_out.collided = 1'b0;
                    n_out.hit_wall = 1'b0;
                    n_out.block_x  = '0;
                    n_out.block_y  = '0;
                end
                CMD_ANSWER: begin
                    // An answer with no move running is dropped without a result.
                    if (r_busy) begin
                        n_out_valid = 1'b1;
                        if (!r_in.cell_in_bounds || r_in.cell_occupied) begin
                            // Blocked: keep the last free cell, report the blocker.
                            n_busy            = 1'b0;
                            n_side_pending    = 1'b0;
                            n_out.result_kind = RES_DONE;
                            n_out.cell_x      = r_pos_x;
                            n_out.cell_y      = r_pos_y;
                            n_out.collided    = 1'b1;
                            n_out.hit_wall    = !r_in.cell_in_bounds;
                            n_out.block_x     = r_probe_x;
                            n_out.block_y     = r_probe_y;
                        end else begin
                            n_pos_x        = r_probe_x;
                            n_pos_y        = r_probe_y;
                            n_out.collided = 1'b0;
                            n_out.hit_wall = 1'b0;
                            n_out.block_x  = '0;
                            n_out.block_y  = '0;
                            if (r_side_pending) begin
                                // Side cell was free: now probe the line cell itself.
                                n_side_pending    = 1'b0;
                                n_probe_x         = r_walk_x;
                                n_probe_y         = r_walk_y;
                                n_out.result_kind = RES_PROBE;
                                n_out.cell_x      = r_walk_x;
                                n_out.cell_y      = r_walk_y;
                            end else if (step_next >= r_major_len) begin
                                // Destination reached.
                                n_step_count      = step_next;
                                n_busy            = 1'b0;
                                n_out.result_kind = RES_DONE;
                                n_out.cell_x      = r_probe_x;
                                n_out.cell_y      = r_probe_y;
                            end else begin
                                n_step_count      = step_next;
                                n_walk_x          = adv_out.walk_x;
                                n_walk_y          = adv_out.walk_y;
                                n_err             = adv_out.err;
                                n_err_prev        = adv_out.err;
                                n_probe_x         = adv_out.probe_x;
                                n_probe_y         = adv_out.probe_y;
                                n_side_pending    = adv_out.side_pending;
                                n_out.result_kind = RES_PROBE;
                                n_out.cell_x      = adv_out.probe_x;
                                n_out.cell_y      = adv_out.probe_y;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Control state is reset; coordinates and line terms are loaded by a start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_busy         <= 1'b0;
            r_side_pending <= 1'b0;
        end else begin
            r_in_valid     <= n_in_valid;
            r_out_valid    <= n_out_valid;
            r_busy         <= n_busy;
            r_side_pending <= n_side_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in         <= n_in;
        r_out        <= n_out;
        r_pos_x      <= n_pos_x;
        r_pos_y      <= n_pos_y;
        r_walk_x     <= n_walk_x;
        r_walk_y     <= n_walk_y;
        r_probe_x    <= n_probe_x;
        r_probe_y    <= n_probe_y;
        r_x_neg      <= n_x_neg;
        r_y_neg      <= n_y_neg;
        r_y_major    <= n_y_major;
        r_major_len  <= n_major_len;
        r_minor_len  <= n_minor_len;
        r_err        <= n_err;
        r_err_prev   <= n_err_prev;
        r_step_count <= n_step_count;
    end

    // A side cell is only ever pending inside a running move.
    a_side_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_side_pending |-> r_busy)
        else $error("side cell pending with no move running");

    // The step count never reaches the major length while a move runs.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step_count < r_major_len))
        else $error("step count ran past the line length");

    // A probe request never carries collision information.
    a_probe_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.result_kind == RES_PROBE))
        |-> (!o_out_data.collided && !o_out_data.hit_wall))
        else $error("probe request flagged as a collision");

    // A wall hit is always a collision, and a clean finish names no blocker.
    a_done_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.result_kind == RES_DONE) && !o_out_data.collided)
        |-> (!o_out_data.hit_wall && (o_out_data.block_x == '0)
             && (o_out_data.block_y == '0)))
        else $error("finished move without collision reports a blocker");

endmodule

// File: rtl/sclw_setup.sv
// Start command decode: direction, major axis and axis lengths of the line.
`timescale 1ns / 1ps

module sclw_setup import sclw_pkg::*; (
    input  t_in_item i_item,
    output t_setup   o_setup
);

    logic signed [LEN_BITS-1:0] dx;
    logic signed [LEN_BITS-1:0] dy;
    t_len                       adx;
    t_len                       ady;

    always_comb begin
        dx  = LEN_BITS'(i_item.dest_x) - LEN_BITS'(i_item.start_x);
        dy  = LEN_BITS'(i_item.dest_y) - LEN_BITS'(i_item.start_y);
        adx = dx[LEN_BITS-1] ? t_len'(-dx) : t_len'(dx);
        ady = dy[LEN_BITS-1] ? t_len'(-dy) : t_len'(dy);

        o_setup.x_neg     = dx[LEN_BITS-1];
        o_setup.y_neg     = dy[LEN_BITS-1];
        o_setup.y_major   = (adx < ady);
        o_setup.major_len = (adx < ady) ? ady : adx;
        o_setup.minor_len = (adx < ady) ? adx : ady;
        o_setup.same_cell = (dx == '0) && (dy == '0);
    end

endmodule

// File: rtl/sclw_advance.sv
// One Bresenham step along the major axis with supercover side-cell selection.
`timescale 1ns / 1ps

module sclw_advance import sclw_pkg::*; (
    input  t_adv_in  i_adv,
    output t_adv_out o_adv
);

    t_err   de;
    t_err   minor2;
    t_err   e1;
    t_err   e2;
    t_err   sum;
    logic   corner;
    t_coord mx;
    t_coord my;
    t_coord fx;
    t_coord fy;

    always_comb begin
        de     = ERR_BITS'({i_adv.major_len, 1'b0});
        minor2 = ERR_BITS'({i_adv.minor_len, 1'b0});
        e1     = i_adv.err + minor2;
        e2     = e1 - de;
        sum    = e2 + i_adv.err_prev;
        corner = (e1 > de);

        // Cell after the major step.
        mx = i_adv.y_major ? i_adv.walk_x : step_coord(i_adv.walk_x, i_adv.x_neg);
        my = i_adv.y_major ? step_coord(i_adv.walk_y, i_adv.y_neg) : i_adv.walk_y;

        // Cell after the minor step as well, when the error overflows.
        fx = (corner && i_adv.y_major) ? step_coord(mx, i_adv.x_neg) : mx;
        fy = (corner && !i_adv.y_major) ? step_coord(my, i_adv.y_neg) : my;

        o_adv.walk_x       = fx;
        o_adv.walk_y       = fy;
        o_adv.err          = corner ? e2 : e1;
        o_adv.probe_x      = fx;
        o_adv.probe_y      = fy;
        o_adv.side_pending = 1'b0;

        if (corner) begin
            if (sum < de) begin
                // The line crosses the cell beside the major step first.
                o_adv.probe_x      = mx;
                o_adv.probe_y      = my;
                o_adv.side_pending = 1'b1;
            end else if (sum > de) begin
                // The line crosses the cell beside the minor step first.
                o_adv.probe_x      = i_adv.y_major ? fx : i_adv.walk_x;
                o_adv.probe_y      = i_adv.y_major ? i_adv.walk_y : fy;
                o_adv.side_pending = 1'b1;
            end
        end
    end

endmodule
